FILE: rtl/kmpr_pkg.sv
// ----------------------------------------------------------------------------
// Keypad matrix press reporter package
// Shared payload types, matrix defaults and the HID usage code table.
// ----------------------------------------------------------------------------
package kmpr_pkg;

  localparam int DEFAULT_ROWS = 5;
  localparam int DEFAULT_COLS = 4;

  // Width of the sampled column field; wider matrices see the extra columns
  // as low.
  localparam int COL_FIELD_W  = 4;

  localparam int CODE_COUNT   = 20;
  localparam int KEY_W        = 8;
  localparam int CODE_W       = 8;

  // Code sent in the release report and for keys without a usage entry.
  localparam logic [CODE_W-1:0] NO_KEY_CODE = 8'h00;

  localparam logic [CODE_W-1:0] USAGE_TABLE [CODE_COUNT] = '{
    8'h53, 8'h54, 8'h55, 8'h56,
    8'h5f, 8'h60, 8'h61, 8'h57,
    8'h5c, 8'h5d, 8'h5e, 8'h00,
    8'h59, 8'h5a, 8'h5b, 8'h58,
    8'h62, 8'h00, 8'h63, 8'h00
  };

  typedef struct packed {
    logic [2:0]             row;
    logic [COL_FIELD_W-1:0] col_bits;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] key_code;
    logic              last;
  } out_item_t;

  // Keys past the end of the table report no code.
  function automatic logic [CODE_W-1:0] usage_code(input logic [KEY_W-1:0] key);
    logic [CODE_W-1:0] code;
    code = NO_KEY_CODE;
    if (key < KEY_W'(CODE_COUNT)) begin
      code = USAGE_TABLE[key[4:0]];
    end
    return code;
  endfunction

endpackage

FILE: rtl/keypad_matrix_press_reporter.sv
// ----------------------------------------------------------------------------
// Keypad matrix press reporter
// Tracks a pressed mark per key of the matrix and reports each new press
// as a key report followed by a release report.
// ----------------------------------------------------------------------------
// A row sample is first held in the job register; its reports are then built into the output register.
// A sample with k new presses gives 2k reports, one report per cycle out of the
// output register while out_ready_i is high, so at most 2*COLS reports per sample.
// Reset: asynchronous, active low; all pressed marks clear and both the held
// row and the output register empty.
module keypad_matrix_press_reporter #(
  parameter int ROWS = kmpr_pkg::DEFAULT_ROWS,
  parameter int COLS = kmpr_pkg::DEFAULT_COLS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  kmpr_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output kmpr_pkg::out_item_t out_item_o
);
  import kmpr_pkg::*;

  localparam int ROW_IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ROW_CMP_W = 5;

  // One pressed mark per key, one packed row of COLS bits per matrix row.
  logic [ROWS-1:0][COLS-1:0] marks_q, marks_d;

  logic                          in_take;
  logic                          row_ok;
  logic [ROW_IDX_W-1:0]          row_idx;
  logic [COLS+COL_FIELD_W-1:0]   col_ext;
  logic [COLS-1:0]               col_high;
  logic [COLS-1:0]               new_press;
  logic                          job_load;

  assign in_take = in_valid_i && in_ready_o;

  // Samples of rows outside the matrix are dropped without touching state.
  assign row_ok  = ROW_CMP_W'(in_item_i.row) < ROW_CMP_W'(ROWS);
  assign row_idx = ROW_IDX_W'(in_item_i.row);

  // Columns beyond the sampled field read as low, so their marks clear.
  assign col_ext  = (COLS + COL_FIELD_W)'(in_item_i.col_bits);
  assign col_high = col_ext[COLS-1:0];

  // A key is newly pressed when its column is high and its mark is clear.
  assign new_press = col_high & ~marks_q[row_idx];

  // Only samples with at least one new press produce reports; the others
  // finish in the cycle of their transfer.
  assign job_load = in_take && row_ok && (new_press != '0);

  // The marks follow the sampled levels directly: a high column sets the
  // mark and a low column clears it.
  always_comb begin
    marks_d = marks_q;
    if (in_take && row_ok) begin
      marks_d[row_idx] = col_high;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marks_q <= '0;
    end else begin
      marks_q <= marks_d;
    end
  end

  // The emitter holds one row's new presses while its reports drain. A new
  // sample is taken in the cycle the last report of the previous one moves
  // into the output register, so the marks are always current.
  kmpr_emitter #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_emitter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (job_load),
    .load_ready_o (in_ready_o),
    .load_row_i   (row_idx),
    .load_mask_i  (new_press),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o)
  );

  // The final report of a sample is always a release report.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.last |-> out_item_o.key_code == NO_KEY_CODE)
    else $error("last report is not a release report");

  // A sample with new presses keeps the input stalled for at least its
  // key report and release report.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_load |=> !in_ready_o)
    else $error("input accepted while reports of a press are pending");

  // A sample for a row outside the matrix leaves every mark unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && !row_ok |=> $stable(marks_q))
    else $error("out-of-range row changed the pressed marks");

  // A report can only appear after a press was loaded or while one drains.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o) || $past(job_load))
    else $error("report produced without a pending press");

endmodule

FILE: rtl/kmpr_emitter.sv
// ----------------------------------------------------------------------------
// Keypad report emitter
// Holds the new-press mask of one row sample and walks it from the lowest
// column up, sending a key report and a release report for each press.
// ----------------------------------------------------------------------------
module kmpr_emitter #(
  parameter int ROWS = kmpr_pkg::DEFAULT_ROWS,
  parameter int COLS = kmpr_pkg::DEFAULT_COLS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 load_valid_i,
  output logic                                 load_ready_o,
  input  logic [(ROWS > 1 ? $clog2(ROWS) : 1)-1:0] load_row_i,
  input  logic [COLS-1:0]                      load_mask_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output kmpr_pkg::out_item_t                  out_item_o
);
  import kmpr_pkg::*;

  localparam int ROW_IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_IDX_W = (COLS > 1) ? $clog2(COLS) : 1;

  logic                 job_valid_q, job_valid_d;
  logic                 job_phase_q, job_phase_d;
  logic [ROW_IDX_W-1:0] job_row_q, job_row_d;
  logic [COLS-1:0]      job_mask_q, job_mask_d;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_item_q, out_item_d;

  logic [COL_IDX_W-1:0] sel_col;
  logic                 sel_found;
  logic [COLS-1:0]      rest_mask;
  logic [KEY_W-1:0]     sel_key;
  logic                 out_load;
  logic                 job_done;
  logic                 load_take;

  // Lowest pending column of the held row.
  always_comb begin
    sel_col   = '0;
    sel_found = 1'b0;
    for (int j = 0; j < COLS; j++) begin
      if (!sel_found && job_mask_q[j]) begin
        sel_col   = COL_IDX_W'(j);
        sel_found = 1'b1;
      end
    end
  end

  assign rest_mask = job_mask_q & (job_mask_q - COLS'(1));
  assign sel_key   = KEY_W'(job_row_q) * KEY_W'(COLS) + KEY_W'(sel_col);

  assign out_load     = job_valid_q && (!out_valid_q || out_ready_i);
  assign job_done     = out_load && job_phase_q && (rest_mask == '0);
  assign load_ready_o = !job_valid_q || job_done;
  assign load_take    = load_valid_i && load_ready_o;

  always_comb begin
    job_valid_d = job_valid_q;
    job_phase_d = job_phase_q;
    job_row_d   = job_row_q;
    job_mask_d  = job_mask_q;
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (out_load) begin
      out_valid_d = 1'b1;
      if (!job_phase_q) begin
        out_item_d.key_code = usage_code(sel_key);
        out_item_d.last     = 1'b0;
        job_phase_d         = 1'b1;
      end else begin
        out_item_d.key_code = NO_KEY_CODE;
        out_item_d.last     = (rest_mask == '0);
        job_phase_d         = 1'b0;
        job_mask_d          = rest_mask;
      end
    end

    if (job_done) begin
      job_valid_d = 1'b0;
    end

    if (load_take) begin
      job_valid_d = 1'b1;
      job_phase_d = 1'b0;
      job_row_d   = load_row_i;
      job_mask_d  = load_mask_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      job_phase_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      job_valid_q <= job_valid_d;
      job_phase_q <= job_phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_row_q  <= job_row_d;
    job_mask_q <= job_mask_d;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
